>>> src/x2hs_pkg.sv
// x2hs_pkg: types, codes and constants shared by the x2 handover sequencer
// depends on nothing; imported by x2hs_step and x2_handover_sequencer
package x2hs_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int LOAD_W        = 11;
    localparam int PCI_W         = 10;
    localparam int CNT_OUT_W     = 16;

    localparam logic [LOAD_W-1:0] LOAD_LIMIT_RESET = 11'd973;

    // procedure state, one-hot
    typedef enum logic [12:0] {
        ST_INIT        = 13'b0000000000001,
        ST_MEAS        = 13'b0000000000010,
        ST_REQ         = 13'b0000000000100,
        ST_REQ_ACK     = 13'b0000000001000,
        ST_SN          = 13'b0000000010000,
        ST_RECONF      = 13'b0000000100000,
        ST_DETACH      = 13'b0000001000000,
        ST_RACH        = 13'b0000010000000,
        ST_RECONF_DONE = 13'b0000100000000,
        ST_PATH        = 13'b0001000000000,
        ST_RELEASE     = 13'b0010000000000,
        ST_COMPLETE    = 13'b0100000000000,
        ST_FAILED      = 13'b1000000000000
    } state_t;

    // external state numbering
    localparam logic [3:0] CODE_INIT        = 4'd0;
    localparam logic [3:0] CODE_MEAS        = 4'd1;
    localparam logic [3:0] CODE_REQ         = 4'd2;
    localparam logic [3:0] CODE_REQ_ACK     = 4'd3;
    localparam logic [3:0] CODE_SN          = 4'd4;
    localparam logic [3:0] CODE_RECONF      = 4'd5;
    localparam logic [3:0] CODE_DETACH      = 4'd6;
    localparam logic [3:0] CODE_RACH        = 4'd7;
    localparam logic [3:0] CODE_RECONF_DONE = 4'd8;
    localparam logic [3:0] CODE_PATH        = 4'd9;
    localparam logic [3:0] CODE_RELEASE     = 4'd10;
    localparam logic [3:0] CODE_COMPLETE    = 4'd11;
    localparam logic [3:0] CODE_FAILED      = 4'd12;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_MEAS  = 3'd1,
        PH_PREP  = 3'd2,
        PH_EXEC  = 3'd3,
        PH_COMPL = 3'd4,
        PH_FAIL  = 3'd5
    } phase_t;

    typedef struct packed {
        logic              restart;
        logic              ho_trigger;
        logic              target_present;
        logic              target_barred;
        logic [LOAD_W-1:0] target_load;
        logic [PCI_W-1:0]  target_pci;
        logic              reconf_accepted;
        logic              rach_ok;
        logic              path_ack;
    } in_t;

    typedef struct packed {
        logic [3:0]           next_proc_state;
        logic [2:0]           phase;
        logic                 running;
        logic [CNT_OUT_W-1:0] failures;
        logic [CNT_OUT_W-1:0] handovers;
        logic [PCI_W-1:0]     serving_pci;
        logic [PCI_W-1:0]     pending_pci;
        logic                 clear_ho_timer;
    } out_t;

    // procedure context carried from step to step
    typedef struct packed {
        state_t                   state;
        phase_t                   phase;
        logic [COUNTER_WIDTH-1:0] fail_count;
        logic [COUNTER_WIDTH-1:0] ho_count;
        logic [PCI_W-1:0]         serving_id;
        logic [PCI_W-1:0]         target_id;
    } ctx_t;

    function automatic logic [3:0] state_code(input state_t s);
        logic [3:0] c;
        case (s)
            ST_INIT:        c = CODE_INIT;
            ST_MEAS:        c = CODE_MEAS;
            ST_REQ:         c = CODE_REQ;
            ST_REQ_ACK:     c = CODE_REQ_ACK;
            ST_SN:          c = CODE_SN;
            ST_RECONF:      c = CODE_RECONF;
            ST_DETACH:      c = CODE_DETACH;
            ST_RACH:        c = CODE_RACH;
            ST_RECONF_DONE: c = CODE_RECONF_DONE;
            ST_PATH:        c = CODE_PATH;
            ST_RELEASE:     c = CODE_RELEASE;
            ST_COMPLETE:    c = CODE_COMPLETE;
            ST_FAILED:      c = CODE_FAILED;
            default:        c = CODE_INIT;
        endcase
        return c;
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // counters leave on a fixed 16 bit field: low bits, zero extended if narrower
    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [COUNTER_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[CNT_OUT_W-1:0];
    endfunction

endpackage

>>> src/x2_handover_sequencer.sv
// x2_handover_sequencer: top level of the x2 handover procedure sequencer
// depends on x2hs_pkg and x2hs_step
//
// usage
// - in channel (in_valid, in_ready, in_data): one beat is one procedure step event
// - out channel (out_valid, out_ready, out_data): exactly one result beat per event,
//   in event order, carrying the procedure state, phase and counters after the step
// - cfg channel (cfg_valid, cfg_ready, cfg_data): writes the admission load limit
//   (q1.10); cfg_ready is always high, write only while no event is in flight
// - path: an accepted event waits in the event register, then its step result is loaded
//   into the result register that drives out_data
// - throughput: one event per cycle while results are taken, set by the single step
//   decode between the event register and the result register; the state updates on
//   the same edge that loads the result, so the following event already sees it
// - stall: while out_ready is low the result holds and the event register takes one more
//   event if it is empty, then in_ready drops until the result is taken
// - reset: procedure in init, phase idle, counters and cell ids zero,
//   load limit 973 (0.95 in q1.10), both channels empty
module x2_handover_sequencer
    import x2hs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LOAD_W-1:0] cfg_data
);

    // event register
    logic              ev_valid_reg;
    logic              ev_valid_next;
    in_t               ev_data_reg;

    // result register
    logic              res_valid_reg;
    logic              res_valid_next;
    out_t              res_data_reg;

    // procedure context and config
    ctx_t              ctx_reg;
    ctx_t              ctx_next;
    out_t              step_result;
    logic [LOAD_W-1:0] limit_reg;

    logic              in_fire;
    logic              res_free;
    logic              ev_advance;

    // result slot is free when empty or being drained this cycle
    assign res_free   = !res_valid_reg || out_ready;
    assign ev_advance = ev_valid_reg && res_free;
    // event register takes a beat when empty or moving on to the result slot
    assign in_ready   = !ev_valid_reg || res_free;
    assign in_fire    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;

    assign out_valid  = res_valid_reg;
    assign out_data   = res_data_reg;

    always_comb
    begin
        if (in_fire)
        begin
            ev_valid_next = 1'b1;
        end
        else if (ev_advance)
        begin
            ev_valid_next = 1'b0;
        end
        else
        begin
            ev_valid_next = ev_valid_reg;
        end

        if (ev_advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    x2hs_step u_step (
        .ctx        (ctx_reg),
        .item       (ev_data_reg),
        .load_limit (limit_reg),
        .ctx_next   (ctx_next),
        .result     (step_result)
    );

    // control state and procedure context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg       <= 1'b0;
            res_valid_reg      <= 1'b0;
            ctx_reg.state      <= ST_INIT;
            ctx_reg.phase      <= PH_IDLE;
            ctx_reg.fail_count <= '0;
            ctx_reg.ho_count   <= '0;
            ctx_reg.serving_id <= '0;
            ctx_reg.target_id  <= '0;
            limit_reg          <= LOAD_LIMIT_RESET;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            res_valid_reg <= res_valid_next;
            if (ev_advance)
            begin
                ctx_reg <= ctx_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ev_data_reg <= in_data;
        end
        if (ev_advance)
        begin
            res_data_reg <= step_result;
        end
    end

    // the procedure state register always holds exactly one state
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(ctx_reg.state))
        else $error("procedure state not one-hot");

    // back-pressure only comes from a full event register behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (ev_valid_reg && res_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    // the handover timer clear only comes with the step into complete
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.clear_ho_timer)
        |-> (res_data_reg.next_proc_state == CODE_COMPLETE))
        else $error("timer clear outside completion");

    // the failure counter never goes backwards
    assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.fail_count >= $past(ctx_reg.fail_count))
        else $error("failure counter decreased");

endmodule

>>> src/x2hs_step.sv
// x2hs_step: one procedure step, current context and event in, next context and result out
// depends on x2hs_pkg
module x2hs_step
    import x2hs_pkg::*;
(
    input  ctx_t              ctx,
    input  in_t               item,
    input  logic [LOAD_W-1:0] load_limit,
    output ctx_t              ctx_next,
    output out_t              result
);

    logic running;
    logic clear_timer;
    logic admit;

    assign admit = item.target_present && !item.target_barred
                   && (item.target_load < load_limit);

    always_comb
    begin
        ctx_next    = ctx;
        running     = 1'b1;
        clear_timer = 1'b0;
        if (item.restart)
        begin
            ctx_next.state = ST_INIT;
            ctx_next.phase = PH_IDLE;
            running        = 1'b0;
        end
        else
        begin
            case (ctx.state)
                ST_INIT:
                begin
                    if (item.ho_trigger)
                    begin
                        ctx_next.state = ST_MEAS;
                        ctx_next.phase = PH_MEAS;
                    end
                end
                ST_MEAS:
                begin
                    if (item.ho_trigger)
                    begin
                        ctx_next.state = ST_REQ;
                        ctx_next.phase = PH_PREP;
                    end
                end
                ST_REQ:
                begin
                    if (admit)
                    begin
                        ctx_next.state = ST_REQ_ACK;
                    end
                    else
                    begin
                        ctx_next.state      = ST_FAILED;
                        ctx_next.phase      = PH_FAIL;
                        ctx_next.fail_count = sat_inc(ctx.fail_count);
                    end
                end
                ST_REQ_ACK:
                begin
                    ctx_next.state = ST_SN;
                end
                ST_SN:
                begin
                    ctx_next.state = ST_RECONF;
                    ctx_next.phase = PH_EXEC;
                end
                ST_RECONF:
                begin
                    if (item.reconf_accepted)
                    begin
                        ctx_next.state     = ST_DETACH;
                        ctx_next.target_id = item.target_present ? item.target_pci : '0;
                    end
                    else
                    begin
                        ctx_next.state      = ST_FAILED;
                        ctx_next.phase      = PH_FAIL;
                        ctx_next.fail_count = sat_inc(ctx.fail_count);
                    end
                end
                ST_DETACH:
                begin
                    ctx_next.state = ST_RACH;
                end
                ST_RACH:
                begin
                    if (item.rach_ok)
                    begin
                        ctx_next.state = ST_RECONF_DONE;
                    end
                    else
                    begin
                        ctx_next.state      = ST_FAILED;
                        ctx_next.phase      = PH_FAIL;
                        ctx_next.fail_count = sat_inc(ctx.fail_count);
                    end
                end
                ST_RECONF_DONE:
                begin
                    ctx_next.state = ST_PATH;
                    ctx_next.phase = PH_COMPL;
                end
                ST_PATH:
                begin
                    if (item.path_ack)
                    begin
                        ctx_next.state = ST_RELEASE;
                    end
                    else
                    begin
                        ctx_next.state      = ST_FAILED;
                        ctx_next.phase      = PH_FAIL;
                        ctx_next.fail_count = sat_inc(ctx.fail_count);
                    end
                end
                ST_RELEASE:
                begin
                    ctx_next.state      = ST_COMPLETE;
                    ctx_next.phase      = PH_COMPL;
                    ctx_next.ho_count   = sat_inc(ctx.ho_count);
                    ctx_next.serving_id = ctx.target_id;
                    ctx_next.target_id  = '0;
                    clear_timer         = 1'b1;
                end
                ST_COMPLETE:
                begin
                    ctx_next.phase = PH_IDLE;
                    running        = 1'b0;
                end
                ST_FAILED:
                begin
                    ctx_next.phase = PH_FAIL;
                    running        = 1'b0;
                end
                default:
                begin
                    running = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        result.next_proc_state = state_code(ctx_next.state);
        result.phase           = ctx_next.phase;
        result.running         = running;
        result.failures        = cnt_out(ctx_next.fail_count);
        result.handovers       = cnt_out(ctx_next.ho_count);
        result.serving_pci     = ctx_next.serving_id;
        result.pending_pci     = ctx_next.target_id;
        result.clear_ho_timer  = clear_timer;
    end

endmodule
